/* design/sdrc_pkg.sv */
// Shared types and constants for the SD block read CRC checker.
// Holds the result kind codes, the start token and the CRC-16/CCITT byte step.
// No dependencies.
package sdrc_pkg;

   typedef enum logic [2:0] {
      KIND_SKIP = 3'd0,
      KIND_DATA = 3'd1,
      KIND_OK   = 3'd2,
      KIND_BAD  = 3'd3,
      KIND_DONE = 3'd4
   } kind_type;

   localparam logic [7:0] START_TOKEN = 8'hFE;

   // Byte-wise CRC-16/CCITT step: poly 0x1021, no reflection.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      c = {crc[7:0], crc[15:8]};
      c = c ^ {8'h00, d};
      c = c ^ {12'h000, c[7:4]};
      c = c ^ {c[3:0], 12'h000};
      c = c ^ {3'b000, c[7:0], 5'b00000};
      return c;
   endfunction

endpackage

/* design/sdrc_crc_step.sv */
// Next-value logic of the running block CRC.
// Clears at a start token, advances on payload bytes and holds otherwise.
// Depends on sdrc_pkg.
module sdrc_crc_step (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  rx_byte,
   input  logic        clear,
   input  logic        advance,
   output logic [15:0] crc_next
);

   always_comb begin
      if (clear) begin
         crc_next = 16'h0000;
      end else if (advance) begin
         crc_next = sdrc_pkg::crc16_byte(crc_cur, rx_byte);
      end else begin
         crc_next = crc_cur;
      end
   end

endmodule

/* design/sd_block_read_crc_checker.sv */
// SD card SPI multi-block read checker, top level.
// Depends on sdrc_pkg and sdrc_crc_step.
//
// Usage: feed every byte read back from the card as one beat on req_*.
// Bytes are skipped until the start token 0xFE; the next BLOCK_BYTES bytes
// are payload and come out with kind payload, their byte and the address to
// store them at. The two CRC bytes that follow (big-endian) are checked
// against the running CRC-16/CCITT; the low CRC byte's beat carries the
// verdict: block ok, CRC error or transfer done (last good block).
// Every input beat yields exactly one result beat on rsp_*.
// block_count and dest_base are taken at the start token that opens a
// transfer; a CRC error ends the transfer.
// A result beat is valid the cycle after its input is accepted, and one beat
// is accepted per cycle unless stalled: all work is the state update between
// the state registers and the single result register. When rsp_tready is low
// the result register holds its beat and req_tready drops until it is taken.
// Synchronous reset returns to hunting with no transfer in progress,
// block_count at one and dest_base at zero.
module sd_block_read_crc_checker #(
   parameter int BLOCK_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] data_byte, [39:8] write_address,
                                    // [55:40] computed_crc
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = $clog2(BLOCK_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);

   localparam logic CSR_BLOCK_COUNT = 1'b0;
   localparam logic CSR_DEST_BASE   = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_DATA   = 2'd1,
      PH_CRC_HI = 2'd2,
      PH_CRC_LO = 2'd3
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [IDX_W-1:0]    byte_index_ff, byte_index_in;
   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          expected_high_ff, expected_high_in;
   logic [23:0]         blocks_left_ff, blocks_left_in;
   logic [31:0]         next_address_ff, next_address_in;
   logic [23:0]         block_count_ff;
   logic [31:0]         dest_base_ff;

   logic                rsp_valid_ff;
   sdrc_pkg::kind_type  kind_ff, kind_in;
   logic [7:0]          data_ff, data_in;
   logic [31:0]         addr_ff, addr_in;
   logic [15:0]         crc_out_ff;

   logic                accept;
   logic                crc_clear;
   logic                crc_advance;
   logic [7:0]          rx;
   logic [23:0]         blocks_dec;

   assign rx         = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign blocks_dec = blocks_left_ff - 24'd1;

   assign crc_clear   = (phase_ff == PH_HUNT) && (rx == sdrc_pkg::START_TOKEN);
   assign crc_advance = (phase_ff == PH_DATA);

   sdrc_crc_step u_crc (
      .crc_cur  (crc_ff),
      .rx_byte  (rx),
      .clear    (crc_clear),
      .advance  (crc_advance),
      .crc_next (crc_in)
   );

   always_comb begin
      phase_in         = phase_ff;
      byte_index_in    = byte_index_ff;
      expected_high_in = expected_high_ff;
      blocks_left_in   = blocks_left_ff;
      next_address_in  = next_address_ff;
      kind_in          = sdrc_pkg::KIND_SKIP;
      data_in          = 8'h00;
      addr_in          = 32'h0000_0000;
      case (phase_ff)
         PH_HUNT: begin
            if (crc_clear) begin
               if (blocks_left_ff == 24'd0) begin
                  // A zero block count still reads one block.
                  blocks_left_in  = (block_count_ff == 24'd0) ? 24'd1 : block_count_ff;
                  next_address_in = dest_base_ff;
               end
               byte_index_in = '0;
               phase_in      = PH_DATA;
            end
         end
         PH_DATA: begin
            kind_in         = sdrc_pkg::KIND_DATA;
            data_in         = rx;
            addr_in         = next_address_ff;
            next_address_in = next_address_ff + 32'd1;
            if (byte_index_ff == LAST_IDX) begin
               byte_index_in = '0;
               phase_in      = PH_CRC_HI;
            end else begin
               byte_index_in = byte_index_ff + IDX_W'(1);
            end
         end
         PH_CRC_HI: begin
            expected_high_in = rx;
            phase_in         = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            phase_in = PH_HUNT;
            if ({expected_high_ff, rx} != crc_ff) begin
               kind_in        = sdrc_pkg::KIND_BAD;
               blocks_left_in = 24'd0;
            end else begin
               blocks_left_in = blocks_dec;
               kind_in = (blocks_dec == 24'd0) ? sdrc_pkg::KIND_DONE : sdrc_pkg::KIND_OK;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         byte_index_ff    <= '0;
         crc_ff           <= 16'h0000;
         expected_high_ff <= 8'h00;
         blocks_left_ff   <= 24'd0;
         next_address_ff  <= 32'h0000_0000;
         block_count_ff   <= 24'd1;
         dest_base_ff     <= 32'h0000_0000;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[23:0];
               CSR_DEST_BASE:   dest_base_ff   <= csr_wdata;
               default:         ;
            endcase
         end
         if (accept) begin
            phase_ff         <= phase_in;
            byte_index_ff    <= byte_index_in;
            crc_ff           <= crc_in;
            expected_high_ff <= expected_high_in;
            blocks_left_ff   <= blocks_left_in;
            next_address_ff  <= next_address_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload; loaded only when a beat is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= kind_in;
         data_ff    <= data_in;
         addr_ff    <= addr_in;
         crc_out_ff <= crc_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {crc_out_ff, addr_ff, data_ff};
   assign rsp_tuser  = kind_ff;

   a_payload_kind: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_DATA) |=> (rsp_valid_ff && kind_ff == sdrc_pkg::KIND_DATA))
      else $error("payload byte not reported as payload");

   a_bad_ends_transfer: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_CRC_LO && {expected_high_ff, rx} != crc_ff)
      |=> (blocks_left_ff == 24'd0 && phase_ff == PH_HUNT))
      else $error("CRC error did not end the transfer");

   a_index_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_DATA) |-> (byte_index_ff == '0))
      else $error("byte index not cleared outside payload");

   a_transfer_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_CRC_HI || phase_ff == PH_CRC_LO)
      |-> (blocks_left_ff != 24'd0))
      else $error("block in progress without an open transfer");

endmodule
